### src/ppd_pkg.sv
// ppd_pkg: widths, codes, stage payload types and the square root step
// shared by the point pair distance pipeline. No dependencies.
package ppd_pkg;

   localparam int NUM_AXES         = 3;
   localparam int DEFAULT_MAX_AXES = 3;
   localparam int OP_W             = 2;
   localparam int COORD_W          = 32;
   localparam int MAG_W            = 32;
   localparam int PROD_W           = 2 * MAG_W;
   localparam int FRAC_W           = 16;
   localparam int TERM_W           = PROD_W - FRAC_W;
   localparam int SUM_W            = TERM_W + 2;
   localparam int VALUE_W          = 52;
   localparam int AXES_W           = 2;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = VALUE_W;
   localparam int ROOT_W           = (SUM_W + FRAC_W) / 2;
   localparam int REM_W            = ROOT_W + 2;
   localparam int SQRT_STEPS_PER_STAGE = 3;
   localparam int SQRT_STAGES      = ROOT_W / SQRT_STEPS_PER_STAGE;

   localparam logic [AXES_W-1:0]  AXES_RESET   = 2'd3;
   localparam logic [VALUE_W-1:0] CUTOFF_RESET = '1;

   // operation codes; bit 1 alone selects cutoff mode
   localparam logic [OP_W-1:0] OP_DISTANCE       = 2'd0;
   localparam logic [OP_W-1:0] OP_SQUARED        = 2'd1;
   localparam logic [OP_W-1:0] OP_SQUARED_CUTOFF = 2'd2;
   localparam int              OP_CUTOFF_BIT     = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AXES_IN_USE    = 1'b0,
      CSR_CUTOFF_SQUARED = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [COORD_W-1:0] first_x;
      logic [COORD_W-1:0] first_y;
      logic [COORD_W-1:0] first_z;
      logic [COORD_W-1:0] second_x;
      logic [COORD_W-1:0] second_y;
      logic [COORD_W-1:0] second_z;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] result_value;
      logic               exceeded;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][TERM_W-1:0] term;
      logic                            distance;
      logic                            cutoff;
   } term_stage_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             distance;
      logic             exceeded;
   } sum_stage_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_step_type;

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic              distance;
      logic              exceeded;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_stage_type;

   // one restoring square root step: brings down one radicand bit pair
   function automatic sqrt_step_type sqrt_step(input logic [REM_W-1:0]  rem,
                                               input logic [ROOT_W-1:0] root,
                                               input logic [1:0]        pair);
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      sqrt_step_type    res;
      rem_sh = {rem, pair};
      trial  = {2'b00, root, 2'b01};
      diff   = rem_sh - trial;
      if (rem_sh >= trial) begin
         res.rem  = diff[REM_W-1:0];
         res.root = {root[ROOT_W-2:0], 1'b1};
      end else begin
         res.rem  = rem_sh[REM_W-1:0];
         res.root = {root[ROOT_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

### src/ppd_stream_if.sv
// ppd_stream_if: valid/ready channel carrying one payload per transfer.
// The payload type is set by the instance; no package dependency.
interface ppd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/ppd_square.sv
// ppd_square: per axis difference magnitude, then exact square truncated to Q32.16.
// Two register stages with their own valid bits. Uses ppd_pkg.
module ppd_square #(
   parameter int MAX_AXES = ppd_pkg::DEFAULT_MAX_AXES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ppd_pkg::NUM_AXES-1:0]    lane_en,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  ppd_pkg::req_payload_type        in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output ppd_pkg::term_stage_type         out_data
);

   logic [ppd_pkg::NUM_AXES-1:0][ppd_pkg::COORD_W-1:0] coord_a;
   logic [ppd_pkg::NUM_AXES-1:0][ppd_pkg::COORD_W-1:0] coord_b;
   logic [ppd_pkg::NUM_AXES-1:0][ppd_pkg::MAG_W-1:0]   mag_in;
   logic [ppd_pkg::NUM_AXES-1:0][ppd_pkg::MAG_W-1:0]   mag_ff;
   logic [ppd_pkg::NUM_AXES-1:0][ppd_pkg::PROD_W-1:0]  prod_in;
   logic [ppd_pkg::NUM_AXES-1:0][ppd_pkg::PROD_W-1:0]  prod_ff;
   logic s1_valid_ff, s2_valid_ff;
   logic s1_ready, s2_ready;
   logic s1_dist_ff, s1_cutoff_ff, s2_dist_ff, s2_cutoff_ff;

   assign coord_a = {in_data.first_z, in_data.first_y, in_data.first_x};
   assign coord_b = {in_data.second_z, in_data.second_y, in_data.second_x};

   for (genvar k = 0; k < ppd_pkg::NUM_AXES; k++) begin : g_lane
      if (k < MAX_AXES) begin : g_used
         logic [ppd_pkg::COORD_W:0] diff;
         logic [ppd_pkg::COORD_W:0] neg;
         always_comb begin
            diff = {coord_a[k][ppd_pkg::COORD_W-1], coord_a[k]}
                 - {coord_b[k][ppd_pkg::COORD_W-1], coord_b[k]};
            neg  = -diff;
            if (!lane_en[k]) begin
               mag_in[k] = '0;
            end else if (diff[ppd_pkg::COORD_W]) begin
               mag_in[k] = neg[ppd_pkg::MAG_W-1:0];
            end else begin
               mag_in[k] = diff[ppd_pkg::MAG_W-1:0];
            end
         end
         assign prod_in[k] = mag_ff[k] * mag_ff[k];
      end else begin : g_unused
         assign mag_in[k]  = '0;
         assign prod_in[k] = '0;
      end
   end

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         mag_ff       <= mag_in;
         s1_dist_ff   <= (in_data.operation == ppd_pkg::OP_DISTANCE);
         s1_cutoff_ff <= in_data.operation[ppd_pkg::OP_CUTOFF_BIT];
      end
      if (s2_ready && s1_valid_ff) begin
         prod_ff      <= prod_in;
         s2_dist_ff   <= s1_dist_ff;
         s2_cutoff_ff <= s1_cutoff_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < ppd_pkg::NUM_AXES; k++) begin
         out_data.term[k] = prod_ff[k][ppd_pkg::PROD_W-1:ppd_pkg::FRAC_W];
      end
      out_data.distance = s2_dist_ff;
      out_data.cutoff   = s2_cutoff_ff;
   end

   assign out_valid = s2_valid_ff;

endmodule

### src/ppd_accum.sv
// ppd_accum: prefix sums over the axes and the early stop on the cutoff limit.
// Three register stages with their own valid bits. Uses ppd_pkg.
module ppd_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ppd_pkg::VALUE_W-1:0]   cutoff,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  ppd_pkg::term_stage_type       in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ppd_pkg::sum_stage_type        out_data
);

   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_ready, b_ready, c_ready;

   logic [ppd_pkg::TERM_W-1:0] a_p0_ff, a_t2_ff;
   logic [ppd_pkg::TERM_W:0]   a_p1_ff;
   logic                       a_dist_ff, a_cutoff_ff;

   logic [ppd_pkg::TERM_W-1:0] b_p0_ff;
   logic [ppd_pkg::TERM_W:0]   b_p1_ff;
   logic [ppd_pkg::SUM_W-1:0]  b_p2_ff;
   logic                       b_gt0_ff, b_gt1_ff, b_dist_ff, b_cutoff_ff;

   logic [ppd_pkg::TERM_W:0]   p1_in;
   logic [ppd_pkg::SUM_W-1:0]  p2_in;
   ppd_pkg::sum_stage_type     c_in, c_ff;

   assign p1_in = {1'b0, in_data.term[0]} + {1'b0, in_data.term[1]};
   assign p2_in = ppd_pkg::SUM_W'(a_p1_ff) + ppd_pkg::SUM_W'(a_t2_ff);

   // first axis whose partial sum passes the limit ends the sum
   always_comb begin
      c_in.distance = b_dist_ff;
      priority if (b_cutoff_ff && b_gt0_ff) begin
         c_in.sum      = ppd_pkg::SUM_W'(b_p0_ff);
         c_in.exceeded = 1'b1;
      end else if (b_cutoff_ff && b_gt1_ff) begin
         c_in.sum      = ppd_pkg::SUM_W'(b_p1_ff);
         c_in.exceeded = 1'b1;
      end else if (b_cutoff_ff && (ppd_pkg::VALUE_W'(b_p2_ff) > cutoff)) begin
         c_in.sum      = b_p2_ff;
         c_in.exceeded = 1'b1;
      end else begin
         c_in.sum      = b_p2_ff;
         c_in.exceeded = 1'b0;
      end
   end

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_p0_ff     <= in_data.term[0];
         a_p1_ff     <= p1_in;
         a_t2_ff     <= in_data.term[2];
         a_dist_ff   <= in_data.distance;
         a_cutoff_ff <= in_data.cutoff;
      end
      if (b_ready && a_valid_ff) begin
         b_p0_ff     <= a_p0_ff;
         b_p1_ff     <= a_p1_ff;
         b_p2_ff     <= p2_in;
         b_gt0_ff    <= ppd_pkg::VALUE_W'(a_p0_ff) > cutoff;
         b_gt1_ff    <= ppd_pkg::VALUE_W'(a_p1_ff) > cutoff;
         b_dist_ff   <= a_dist_ff;
         b_cutoff_ff <= a_cutoff_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_ff <= c_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_ff;

endmodule

### src/ppd_sqrt.sv
// ppd_sqrt: pipelined restoring square root, a few root bits per stage, with the
// squared sum carried alongside; drives the result register. Uses ppd_pkg.
module ppd_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ppd_pkg::sum_stage_type    in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ppd_pkg::rsp_payload_type  out_data
);

   localparam int LAST = ppd_pkg::SQRT_STAGES - 1;

   logic                    valid_ff    [ppd_pkg::SQRT_STAGES];
   logic                    stage_ready [ppd_pkg::SQRT_STAGES];
   ppd_pkg::sqrt_stage_type data_ff     [ppd_pkg::SQRT_STAGES];
   ppd_pkg::sqrt_stage_type head;

   always_comb begin
      head.sum      = in_data.sum;
      head.distance = in_data.distance;
      head.exceeded = in_data.exceeded;
      head.rem      = '0;
      head.root     = '0;
   end

   for (genvar g = 0; g < ppd_pkg::SQRT_STAGES; g++) begin : g_stage
      ppd_pkg::sqrt_stage_type prev;
      ppd_pkg::sqrt_stage_type data_in;
      ppd_pkg::sqrt_step_type  chain [ppd_pkg::SQRT_STEPS_PER_STAGE+1];
      logic [2*ppd_pkg::ROOT_W-1:0] rad;
      logic prev_valid;
      logic next_ready;

      if (g == 0) begin : g_head
         assign prev       = head;
         assign prev_valid = in_valid;
      end else begin : g_body
         assign prev       = data_ff[g-1];
         assign prev_valid = valid_ff[g-1];
      end

      if (g == LAST) begin : g_tail
         assign next_ready = out_ready;
      end else begin : g_mid
         assign next_ready = stage_ready[g+1];
      end

      assign rad      = {prev.sum, ppd_pkg::FRAC_W'(0)};
      assign chain[0] = '{rem: prev.rem, root: prev.root};

      // radicand bit pairs are consumed from the top down
      for (genvar s = 0; s < ppd_pkg::SQRT_STEPS_PER_STAGE; s++) begin : g_step
         localparam int PAIR_LO =
            2 * (ppd_pkg::ROOT_W - 1 - (g * ppd_pkg::SQRT_STEPS_PER_STAGE + s));
         assign chain[s+1] = ppd_pkg::sqrt_step(chain[s].rem, chain[s].root,
                                                rad[PAIR_LO +: 2]);
      end

      always_comb begin
         data_in      = prev;
         data_in.rem  = chain[ppd_pkg::SQRT_STEPS_PER_STAGE].rem;
         data_in.root = chain[ppd_pkg::SQRT_STEPS_PER_STAGE].root;
      end

      assign stage_ready[g] = !valid_ff[g] || next_ready;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (stage_ready[g]) begin
            valid_ff[g] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[g] && prev_valid) begin
            data_ff[g] <= data_in;
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[LAST];

   always_comb begin
      if (data_ff[LAST].distance) begin
         out_data.result_value = ppd_pkg::VALUE_W'(data_ff[LAST].root);
      end else begin
         out_data.result_value = ppd_pkg::VALUE_W'(data_ff[LAST].sum);
      end
      out_data.exceeded = data_ff[LAST].exceeded;
   end

endmodule

### src/point_pair_distance.sv
// point_pair_distance: top level; configuration registers and the three pipeline parts.
// Depends on ppd_pkg, ppd_stream_if, ppd_square, ppd_accum and ppd_sqrt.

// Takes one point pair per clock while results are taken, and returns one result per
// pair, in order: 2 stages form the per axis squares, 3 stages add the axes and apply
// the cutoff, and 11 stages of the square root unit (3 root bits each) finish the item,
// the last one being the result register. Every stage has its own valid bit and
// loads whenever it is empty or its successor moves, so a stalled result only holds
// back the stages behind it and gaps in the stream close up. Operation 0 gives the
// distance in Q17.16 with the square root truncated, 1 the squared distance in Q34.16,
// 2 (and 3) the squared distance with the early stop on cutoff_squared. Write the
// configuration registers only while no transfer is in flight.
module point_pair_distance #(
   parameter int MAX_AXES = ppd_pkg::DEFAULT_MAX_AXES
) (
   input  logic                                clock,
   input  logic                                reset,
   ppd_stream_if.sink                          req_chan,
   ppd_stream_if.source                        rsp_chan,
   input  logic                                csr_write_en,
   input  logic [ppd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppd_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic [ppd_pkg::AXES_W-1:0]   axes_ff;
   logic [ppd_pkg::VALUE_W-1:0]  cutoff_ff;
   logic [ppd_pkg::AXES_W-1:0]   axes_eff;
   logic [ppd_pkg::NUM_AXES-1:0] lane_en;

   logic                     sq_valid, sq_ready;
   ppd_pkg::term_stage_type  sq_data;
   logic                     acc_valid, acc_ready;
   ppd_pkg::sum_stage_type   acc_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         axes_ff   <= ppd_pkg::AXES_RESET;
         cutoff_ff <= ppd_pkg::CUTOFF_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ppd_pkg::CSR_AXES_IN_USE: begin
               axes_ff <= csr_write_data[ppd_pkg::AXES_W-1:0];
            end
            ppd_pkg::CSR_CUTOFF_SQUARED: begin
               cutoff_ff <= csr_write_data[ppd_pkg::VALUE_W-1:0];
            end
            default: begin
               axes_ff <= axes_ff;
            end
         endcase
      end
   end

   // zero axes counts as one, and the count saturates at MAX_AXES
   always_comb begin
      priority if (axes_ff == '0) begin
         axes_eff = ppd_pkg::AXES_W'(1);
      end else if (axes_ff > ppd_pkg::AXES_W'(MAX_AXES)) begin
         axes_eff = ppd_pkg::AXES_W'(MAX_AXES);
      end else begin
         axes_eff = axes_ff;
      end
      for (int k = 0; k < ppd_pkg::NUM_AXES; k++) begin
         lane_en[k] = ppd_pkg::AXES_W'(k) < axes_eff;
      end
   end

   ppd_square #(
      .MAX_AXES (MAX_AXES)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .lane_en   (lane_en),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_chan.payload),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_data  (sq_data)
   );

   ppd_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .cutoff    (cutoff_ff),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_data   (sq_data),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_data  (acc_data)
   );

   ppd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (acc_ready),
      .in_data   (acc_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.payload)
   );

`ifndef NO_ASSERTIONS
   // an open output means every stage can move
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("input stalled while the output is taking transfers");

   // a sum of three axes is below 2^50 and a root below 2^33
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.result_value[ppd_pkg::VALUE_W-1:ppd_pkg::SUM_W]
                          == '0))
      else $error("result value out of range");

   // the early stop only exists in cutoff mode, never for the distance
   a_flag_mode: assert property (@(posedge clock) disable iff (reset)
      (acc_valid && acc_data.exceeded) |-> !acc_data.distance)
      else $error("exceeded raised on a distance operation");
`endif

endmodule

### dv/testbench.sv
// testbench: self-checking bench for point_pair_distance; directed and random pairs are
// pushed through the valid/ready channels under random idling and compared with a
// local predictor. Depends on ppd_pkg, ppd_stream_if and point_pair_distance.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ppd_pkg::OP_W-1:0]    OP_UNUSED      = 2'd3;
   localparam logic [ppd_pkg::COORD_W-1:0] COORD_MIN      = 32'h8000_0000;
   localparam logic [ppd_pkg::COORD_W-1:0] COORD_MAX      = 32'h7FFF_FFFF;
   localparam logic [ppd_pkg::COORD_W-1:0] Q_ONE          = 32'h0001_0000;
   localparam int                          DIST_W         = 34;
   localparam int                          NUM_PHASES     = 8;
   localparam int                          PHASE_ITEMS    = 110;
   localparam int                          WATCHDOG_LIMIT = 4000;
   localparam int                          SETTLE_CYCLES  = 24;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [ppd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ppd_pkg::CSR_DATA_W-1:0]  csr_write_data;

   ppd_stream_if #(.payload_type(ppd_pkg::req_payload_type)) req_chan ();
   ppd_stream_if #(.payload_type(ppd_pkg::rsp_payload_type)) rsp_chan ();

   point_pair_distance u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ppd_pkg::req_payload_type queued_pairs[$];
   ppd_pkg::rsp_payload_type expected_distances[$];

   logic [ppd_pkg::AXES_W-1:0]  axes_cfg;
   logic [ppd_pkg::VALUE_W-1:0] cutoff_cfg;
   logic               hold_sender;
   logic               sender_steady;
   logic               receiver_steady;
   int unsigned        error_count = 0;
   int                 burst_left;
   int                 gap_left;
   int                 stall_count;
   int                 stall_period;
   int                 stall_low;
   int                 idle_cycles = 0;

   // expected result of one point pair under the given register settings
   function automatic ppd_pkg::rsp_payload_type pair_distance(
         input ppd_pkg::req_payload_type pair,
         input logic [ppd_pkg::AXES_W-1:0] axes,
         input logic [ppd_pkg::VALUE_W-1:0] cutoff);
      logic [ppd_pkg::COORD_W-1:0]    p [ppd_pkg::NUM_AXES];
      logic [ppd_pkg::COORD_W-1:0]    q [ppd_pkg::NUM_AXES];
      logic signed [ppd_pkg::COORD_W:0] delta;
      logic [ppd_pkg::COORD_W:0]      mag;
      logic [2*ppd_pkg::COORD_W+1:0]  square;
      logic [ppd_pkg::VALUE_W-1:0]    sum;
      logic [DIST_W-1:0]              root;
      logic [DIST_W-1:0]              cand;
      logic [2*DIST_W-1:0]            cand_sq;
      logic [2*DIST_W-1:0]            radicand;
      int                             axes_used;
      ppd_pkg::rsp_payload_type       res;
      p = '{pair.first_x, pair.first_y, pair.first_z};
      q = '{pair.second_x, pair.second_y, pair.second_z};
      axes_used = (axes == 0) ? 1 : int'(axes);
      if (axes_used > ppd_pkg::DEFAULT_MAX_AXES)
         axes_used = ppd_pkg::DEFAULT_MAX_AXES;
      sum = '0;
      res.exceeded = 1'b0;
      for (int k = 0; k < axes_used; k++) begin
         delta  = $signed({p[k][ppd_pkg::COORD_W-1], p[k]})
                - $signed({q[k][ppd_pkg::COORD_W-1], q[k]});
         mag    = delta[ppd_pkg::COORD_W] ? -delta : delta;
         square = mag * mag;
         sum    = sum + square[2*ppd_pkg::COORD_W+1:ppd_pkg::FRAC_W];
         if (pair.operation[ppd_pkg::OP_CUTOFF_BIT] && sum > cutoff) begin
            res.exceeded = 1'b1;
            break;
         end
      end
      if (pair.operation == ppd_pkg::OP_DISTANCE) begin
         // largest root whose square fits under sum scaled by 2^16
         radicand = {sum, {ppd_pkg::FRAC_W{1'b0}}};
         root = '0;
         for (int b = DIST_W - 1; b >= 0; b--) begin
            cand    = root | (DIST_W'(1) << b);
            cand_sq = cand * cand;
            if (cand_sq <= radicand)
               root = cand;
         end
         res.result_value = ppd_pkg::VALUE_W'(root);
      end else begin
         res.result_value = sum;
      end
      return res;
   endfunction

   function automatic ppd_pkg::req_payload_type make_pair(
         input logic [ppd_pkg::OP_W-1:0] op,
         input logic [ppd_pkg::COORD_W-1:0] fx, fy, fz,
         input logic [ppd_pkg::COORD_W-1:0] sx, sy, sz);
      ppd_pkg::req_payload_type pair;
      pair.operation = op;
      pair.first_x   = fx;
      pair.first_y   = fy;
      pair.first_z   = fz;
      pair.second_x  = sx;
      pair.second_y  = sy;
      pair.second_z  = sz;
      return pair;
   endfunction

   function automatic logic [ppd_pkg::COORD_W-1:0] random_coord();
      logic [ppd_pkg::COORD_W-1:0] c;
      case ($urandom_range(0, 4))
         0, 1: c = $urandom;
         2: c = $urandom_range(0, 1 << 21) - (1 << 20);
         3: begin
            case ($urandom_range(0, 3))
               0: c = COORD_MIN;
               1: c = COORD_MAX;
               2: c = '0;
               default: c = '1;
            endcase
         end
         default: c = $urandom_range(0, 1 << 27) - (1 << 26);
      endcase
      return c;
   endfunction

   // second point is often close to the first so that cutoffs near 2^30 matter
   function automatic logic [ppd_pkg::COORD_W-1:0] partner_coord(
         input logic [ppd_pkg::COORD_W-1:0] c);
      logic [ppd_pkg::COORD_W-1:0] r;
      if ($urandom_range(0, 1) == 0)
         r = c + ($urandom_range(0, 1 << 24) - (1 << 23));
      else
         r = random_coord();
      return r;
   endfunction

   function automatic ppd_pkg::req_payload_type random_pair();
      ppd_pkg::req_payload_type pair;
      pair.operation = ppd_pkg::OP_W'($urandom_range(0, 3));
      pair.first_x   = random_coord();
      pair.first_y   = random_coord();
      pair.first_z   = random_coord();
      pair.second_x  = partner_coord(pair.first_x);
      pair.second_y  = partner_coord(pair.first_y);
      pair.second_z  = partner_coord(pair.first_z);
      return pair;
   endfunction

   task automatic write_register(input ppd_pkg::csr_index_type index,
                                 input logic [ppd_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (index == ppd_pkg::CSR_AXES_IN_USE)
         axes_cfg = data[ppd_pkg::AXES_W-1:0];
      else
         cutoff_cfg = data[ppd_pkg::VALUE_W-1:0];
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (queued_pairs.size() != 0 || req_chan.valid || expected_distances.size() != 0);
   endtask

   // sender

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = $urandom_range(1, 32);
         gap_left = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left > 0 && !sender_steady) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (queued_pairs.size() != 0 && !hold_sender) begin
            req_chan.valid   <= 1'b1;
            req_chan.payload <= queued_pairs.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 32);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern: unless receiver_steady is set, ready is low while the period counter is below stall_low

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_count  = 0;
         stall_period = 4;
         stall_low    = 1;
      end else begin
         stall_count++;
         if (stall_count >= stall_period) begin
            stall_count  = 0;
            stall_period = $urandom_range(2, 12);
            stall_low    = $urandom_range(0, stall_period - 1);
         end
         rsp_chan.ready <= receiver_steady || (stall_count >= stall_low);
      end
   end

   // monitor and scoreboard

   always @(posedge clock) begin : monitor
      ppd_pkg::rsp_payload_type want;
      ppd_pkg::rsp_payload_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            expected_distances.push_back(pair_distance(req_chan.payload, axes_cfg, cutoff_cfg));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (expected_distances.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result transfer: value %h exceeded %b",
                           got.result_value, got.exceeded);
            end else begin
               want = expected_distances.pop_front();
               if (got.result_value !== want.result_value || got.exceeded !== want.exceeded)
               begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: value exp %h got %h, exceeded exp %b got %b",
                              want.result_value, got.result_value,
                              want.exceeded, got.exceeded);
               end
            end
         end
      end
   end

   // watchdog: only counts while work is outstanding

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (queued_pairs.size() == 0 && !req_chan.valid && expected_distances.size() == 0))
      begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("** point_pair_distance: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      logic [ppd_pkg::CSR_DATA_W-1:0] cutoff;
      logic [ppd_pkg::AXES_W-1:0]     axes;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      hold_sender      = 1'b0;
      sender_steady    = 1'b0;
      receiver_steady  = 1'b0;
      axes_cfg         = ppd_pkg::AXES_RESET;
      cutoff_cfg       = ppd_pkg::CUTOFF_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // a few pairs under the reset register values
      @(negedge clock);
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED_CUTOFF, COORD_MIN, COORD_MIN,
                                       COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_DISTANCE, COORD_MAX, COORD_MIN, COORD_MAX,
                                       COORD_MIN, COORD_MAX, COORD_MIN));
      queued_pairs.push_back(random_pair());
      queued_pairs.push_back(random_pair());
      wait_drained();

      // directed: cutoff is exactly 256.0 squared
      write_register(ppd_pkg::CSR_AXES_IN_USE, ppd_pkg::CSR_DATA_W'(3));
      write_register(ppd_pkg::CSR_CUTOFF_SQUARED, 52'h1_0000_0000);
      @(negedge clock);
      queued_pairs.push_back(make_pair(ppd_pkg::OP_DISTANCE, 0, 0, 0, 0, 0, 0));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED, 0, 0, 0, 0, 0, 0));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED_CUTOFF, 0, 0, 0, 0, 0, 0));
      queued_pairs.push_back(make_pair(OP_UNUSED, 0, 0, 0, 0, 0, 0));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_DISTANCE, COORD_MIN, COORD_MIN, COORD_MIN,
                                       COORD_MAX, COORD_MAX, COORD_MAX));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED, COORD_MIN, COORD_MIN, COORD_MIN,
                                       COORD_MAX, COORD_MAX, COORD_MAX));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED_CUTOFF, COORD_MIN, COORD_MIN,
                                       COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_DISTANCE, COORD_MAX, COORD_MAX, COORD_MAX,
                                       COORD_MIN, COORD_MIN, COORD_MIN));
      queued_pairs.push_back(make_pair(OP_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX,
                                       COORD_MIN, COORD_MIN, COORD_MIN));
      // one lsb apart: square truncates to zero
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED, 1, 1, 1, 0, 0, 0));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED, 32'h100, 0, 0, 0, 0, 0));
      // sum equal to the cutoff does not stop
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED_CUTOFF, 32'h0100_0000, 0, 0,
                                       0, 0, 0));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED_CUTOFF, 32'hFF00_0000, 0, 0,
                                       0, 0, 0));
      // stop on the second axis, third axis must be ignored
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED_CUTOFF, 32'h0100_0000, 32'h100,
                                       COORD_MAX, 0, 0, COORD_MIN));
      // stop on the last axis
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED_CUTOFF, 0, 0, 32'h0100_0001,
                                       0, 0, 0));
      // stop on the first axis
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED_CUTOFF, 32'h0200_0000, COORD_MAX,
                                       COORD_MAX, 0, COORD_MIN, COORD_MIN));
      queued_pairs.push_back(make_pair(OP_UNUSED, 32'h0200_0000, COORD_MAX, COORD_MAX,
                                       0, COORD_MIN, COORD_MIN));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED, 32'h0200_0000, COORD_MAX,
                                       COORD_MAX, 0, COORD_MIN, COORD_MIN));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_DISTANCE, 32'h0003_0000, 0, 0,
                                       0, 32'h0004_0000, 0));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_DISTANCE, Q_ONE, Q_ONE, 0, 0, 0, 0));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_SQUARED, '1, '1, '1, 1, 1, 1));
      queued_pairs.push_back(make_pair(ppd_pkg::OP_DISTANCE, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                       32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                                       32'h5555_5555));
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin axes = 3; cutoff = ppd_pkg::CUTOFF_RESET; end
            1: begin axes = 1; cutoff = '0; end
            2: begin axes = 2; cutoff = ppd_pkg::CSR_DATA_W'(1) << 47; end
            3: begin axes = 0; cutoff = ppd_pkg::CSR_DATA_W'(1) << 30; end
            4: begin axes = 3; cutoff = {$urandom, $urandom}; end
            5: begin axes = 2; cutoff = ppd_pkg::CSR_DATA_W'(3) << 46; end
            6: begin axes = 1; cutoff = ppd_pkg::CSR_DATA_W'(1) << 20; end
            default: begin axes = 3; cutoff = ppd_pkg::CSR_DATA_W'(1) << 31; end
         endcase
         write_register(ppd_pkg::CSR_AXES_IN_USE, ppd_pkg::CSR_DATA_W'(axes));
         write_register(ppd_pkg::CSR_CUTOFF_SQUARED, cutoff);
         @(negedge clock);
         sender_steady   = (ph == 2 || ph == 5);
         receiver_steady = (ph == 2 || ph == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 3 && n == PHASE_ITEMS / 2) begin
               // hold the sender with work queued until the pipeline is empty
               do @(negedge clock);
               while (queued_pairs.size() > 10);
               hold_sender = 1'b1;
               do @(negedge clock);
               while (req_chan.valid || expected_distances.size() != 0);
               hold_sender = 1'b0;
            end
            queued_pairs.push_back(random_pair());
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_distances.size() != 0)
         error_count++;
      if (error_count == 0)
         $display("** point_pair_distance: PASSED **");
      else
         $display("** point_pair_distance: FAILED **");
      $finish;
   end

endmodule

### filelist.f
src/ppd_pkg.sv
src/ppd_stream_if.sv
src/ppd_square.sv
src/ppd_accum.sv
src/ppd_sqrt.sv
src/point_pair_distance.sv
dv/testbench.sv
